// ----- sv/mip_chain_surface_offset_top_defines.svh -----
// ----------------------------------------------------------------------------
// Mip chain surface offset: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MIP_CHAIN_SURFACE_OFFSET_TOP_DEFINES_SVH
`define MIP_CHAIN_SURFACE_OFFSET_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define MCSO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define MCSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mcso_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset package
// Widths, codes and shared types for the mip chain layout block.
// ----------------------------------------------------------------------------
package mcso_pkg;

    localparam int MAX_LEVELS  = 13;
    localparam int PITCH_ALIGN = 64;
    localparam int PITCH_SHIFT = 6;
    localparam int MAX_SLICES  = 512;
    localparam int CUBE_FACES  = 6;

    localparam int KIND_W     = 2;
    localparam int DIM_W      = 13;
    localparam int DEPTH_W    = 10;
    localparam int LEVEL_W    = 4;
    localparam int BPT_W      = 5;
    localparam int FACE_W     = 3;
    localparam int SLICE_W    = 9;
    localparam int ADDR_W     = 38;
    localparam int PITCH_W    = DIM_W + 1;
    localparam int ROWB_W     = PITCH_W + BPT_W;
    localparam int ROWS_W     = DIM_W + 1;
    localparam int CHAIN_W    = ROWB_W + ROWS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [KIND_W-1:0] KIND_PLAIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUBE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VOLUME = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXTURE_KIND    = 3'd0,
        CFG_BASE_WIDTH      = 3'd1,
        CFG_BASE_HEIGHT     = 3'd2,
        CFG_BASE_DEPTH      = 3'd3,
        CFG_MIP_LIMIT       = 3'd4,
        CFG_BYTES_PER_TEXEL = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUM,
        BK_MUL_CHAIN,
        BK_MUL_OUT,
        BK_HOLD
    } back_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  texture_kind;
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [LEVEL_W-1:0] mip_limit;
        logic [BPT_W-1:0]   bytes_per_texel;
    } cfg_regs_t;

    typedef struct packed {
        logic [DIM_W-1:0]   height;
        logic [LEVEL_W-1:0] last;
        logic [LEVEL_W-1:0] level;
        logic [PITCH_W-1:0] pitch;
        logic [BPT_W-1:0]   bpt;
        logic [SLICE_W-1:0] slot;
        logic [DEPTH_W-1:0] chains;
        logic               bad;
        logic [DIM_W-1:0]   level_width;
        logic [DIM_W-1:0]   level_height;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- sv/mcso_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset channels
// Request, response and configuration valid/ready channels.
// ----------------------------------------------------------------------------
interface mcso_req_if import mcso_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FACE_W-1:0]  face_index;
    logic [LEVEL_W-1:0] mip_level;
    logic [SLICE_W-1:0] slice_index;

    modport source (output valid, face_index, mip_level, slice_index, input ready);
    modport sink   (input valid, face_index, mip_level, slice_index, output ready);
endinterface

interface mcso_rsp_if import mcso_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  byte_offset;
    logic [DIM_W-1:0]   pitch_texels;
    logic [DIM_W-1:0]   level_width;
    logic [DIM_W-1:0]   level_height;
    logic [ADDR_W-1:0]  total_bytes;
    logic               bad_request;

    modport source (output valid, byte_offset, pitch_texels, level_width, level_height,
                    total_bytes, bad_request, input ready);
    modport sink   (input valid, byte_offset, pitch_texels, level_width, level_height,
                    total_bytes, bad_request, output ready);
endinterface

interface mcso_cfg_if import mcso_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/mip_chain_surface_offset_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset top level
// Linear mip chain layout: offset, pitch, level size and total size per request.
// ----------------------------------------------------------------------------
// The back end sums level heights one level a cycle, from level 0 to the clamped last
// level, then scales and places the chain; it takes one request at a time.
// The two-entry queue takes up to two more requests while a response waits.
// Reset: async active low; clears the queue and sequencer, loads register defaults.
module mip_chain_surface_offset_top import mcso_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mcso_cfg_if.sink    cfg,
    mcso_req_if.sink    req,
    mcso_rsp_if.source  rsp
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;
    logic      push;
    logic      pop;
    q_entry_t  push_entry;
    q_entry_t  pop_entry;
    q_stat_t   q_stat;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TEXTURE_KIND:    cfg_next.texture_kind    = cfg.data[KIND_W-1:0];
                CFG_BASE_WIDTH:      cfg_next.base_width      = cfg.data[DIM_W-1:0];
                CFG_BASE_HEIGHT:     cfg_next.base_height     = cfg.data[DIM_W-1:0];
                CFG_BASE_DEPTH:      cfg_next.base_depth      = cfg.data[DEPTH_W-1:0];
                CFG_MIP_LIMIT:       cfg_next.mip_limit       = cfg.data[LEVEL_W-1:0];
                CFG_BYTES_PER_TEXEL: cfg_next.bytes_per_texel = cfg.data[BPT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.texture_kind    <= KIND_PLAIN;
            cfg_reg.base_width      <= DIM_W'(1);
            cfg_reg.base_height     <= DIM_W'(1);
            cfg_reg.base_depth      <= DEPTH_W'(1);
            cfg_reg.mip_limit       <= '0;
            cfg_reg.bytes_per_texel <= BPT_W'(4);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mcso_front u_front (
        .req    (req),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .push   (push),
        .entry  (push_entry)
    );

    mcso_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    mcso_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_entry (pop_entry),
        .q_stat  (q_stat),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

// ----- sv/mcso_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module mcso_queue import mcso_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t pop_entry,
    output q_stat_t  stat
);

    q_entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- sv/mcso_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset front end
// Accepts requests, clamps the configuration and classifies each request.
// ----------------------------------------------------------------------------
module mcso_front import mcso_pkg::*; (
    mcso_req_if.sink  req,
    input  cfg_regs_t cfg,
    input  q_stat_t   q_stat,
    output logic      push,
    output q_entry_t  entry
);

    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DEPTH_W-1:0] d;
    logic [LEVEL_W-1:0] last;
    logic [DIM_W-1:0]   lw;
    logic [DIM_W-1:0]   lh;
    logic               bad_sel;

    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full;

    always_comb
    begin
        w = (cfg.base_width == '0) ? DIM_W'(1) : cfg.base_width;
        h = (cfg.base_height == '0) ? DIM_W'(1) : cfg.base_height;
        d = (cfg.base_depth == '0) ? DEPTH_W'(1) : cfg.base_depth;
        if (d > DEPTH_W'(MAX_SLICES))
        begin
            d = DEPTH_W'(MAX_SLICES);
        end
        last = (cfg.mip_limit > LEVEL_W'(MAX_LEVELS - 1)) ?
               LEVEL_W'(MAX_LEVELS - 1) : cfg.mip_limit;

        lw = w >> req.mip_level;
        lh = h >> req.mip_level;
        if (lw == '0)
        begin
            lw = DIM_W'(1);
        end
        if (lh == '0)
        begin
            lh = DIM_W'(1);
        end

        entry.height       = h;
        entry.last         = last;
        entry.level        = req.mip_level;
        entry.pitch        = ((PITCH_W'(w) + PITCH_W'(PITCH_ALIGN - 1)) >> PITCH_SHIFT)
                             << PITCH_SHIFT;
        entry.bpt          = cfg.bytes_per_texel;
        entry.level_width  = lw;
        entry.level_height = lh;

        // pick which chain the request lands in
        case (cfg.texture_kind)
            KIND_CUBE:
            begin
                entry.chains = DEPTH_W'(CUBE_FACES);
                entry.slot   = SLICE_W'(req.face_index);
                bad_sel      = (req.face_index >= FACE_W'(CUBE_FACES));
            end
            KIND_VOLUME:
            begin
                entry.chains = d;
                entry.slot   = req.slice_index;
                bad_sel      = (DEPTH_W'(req.slice_index) >= d);
            end
            default:
            begin
                entry.chains = DEPTH_W'(1);
                entry.slot   = '0;
                bad_sel      = 1'b0;
            end
        endcase

        entry.bad = bad_sel || (req.mip_level > last);
    end

endmodule

// ----- sv/mcso_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset back end
// Walks the mip levels one per cycle, then scales and places the chain.
// ----------------------------------------------------------------------------
module mcso_back import mcso_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  q_entry,
    input  q_stat_t   q_stat,
    output logic      pop,
    mcso_rsp_if.source rsp
);

    back_state_t        state_reg;
    back_state_t        state_next;
    q_entry_t           ent_reg;
    q_entry_t           ent_next;
    logic [ROWB_W-1:0]  row_bytes_reg;
    logic [ROWB_W-1:0]  row_bytes_next;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [LEVEL_W-1:0] lvl_next;
    logic [ROWS_W-1:0]  rows_all_reg;
    logic [ROWS_W-1:0]  rows_all_next;
    logic [ROWS_W-1:0]  rows_before_reg;
    logic [ROWS_W-1:0]  rows_before_next;
    logic [CHAIN_W-1:0] chain_reg;
    logic [CHAIN_W-1:0] chain_next;
    logic [CHAIN_W-1:0] before_reg;
    logic [CHAIN_W-1:0] before_next;
    logic [ADDR_W-1:0]  offset_reg;
    logic [ADDR_W-1:0]  offset_next;
    logic [ADDR_W-1:0]  total_reg;
    logic [ADDR_W-1:0]  total_next;
    logic [DIM_W-1:0]   lh;

    assign rsp.valid        = (state_reg == BK_HOLD);
    assign rsp.byte_offset  = offset_reg;
    assign rsp.total_bytes  = total_reg;
    assign rsp.pitch_texels = ent_reg.pitch[DIM_W-1:0];
    assign rsp.level_width  = ent_reg.level_width;
    assign rsp.level_height = ent_reg.level_height;
    assign rsp.bad_request  = ent_reg.bad;

    always_comb
    begin
        state_next       = state_reg;
        ent_next         = ent_reg;
        row_bytes_next   = row_bytes_reg;
        lvl_next         = lvl_reg;
        rows_all_next    = rows_all_reg;
        rows_before_next = rows_before_reg;
        chain_next       = chain_reg;
        before_next      = before_reg;
        offset_next      = offset_reg;
        total_next       = total_reg;
        pop              = 1'b0;

        lh = ent_reg.height >> lvl_reg;
        if (lh == '0)
        begin
            lh = DIM_W'(1);
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop              = 1'b1;
                    ent_next         = q_entry;
                    row_bytes_next   = ROWB_W'(q_entry.pitch) * ROWB_W'(q_entry.bpt);
                    lvl_next         = '0;
                    rows_all_next    = '0;
                    rows_before_next = '0;
                    state_next       = BK_SUM;
                end
            end
            BK_SUM:
            begin
                // accumulate level heights; levels below the asked one go ahead of it
                rows_all_next = rows_all_reg + ROWS_W'(lh);
                if (lvl_reg < ent_reg.level)
                begin
                    rows_before_next = rows_before_reg + ROWS_W'(lh);
                end
                lvl_next = lvl_reg + LEVEL_W'(1);
                if (lvl_reg == ent_reg.last)
                begin
                    state_next = BK_MUL_CHAIN;
                end
            end
            BK_MUL_CHAIN:
            begin
                chain_next  = CHAIN_W'(row_bytes_reg) * CHAIN_W'(rows_all_reg);
                before_next = CHAIN_W'(row_bytes_reg) * CHAIN_W'(rows_before_reg);
                state_next  = BK_MUL_OUT;
            end
            BK_MUL_OUT:
            begin
                offset_next = ent_reg.bad ? '0 :
                              ADDR_W'(ent_reg.slot) * ADDR_W'(chain_reg) + ADDR_W'(before_reg);
                total_next  = ADDR_W'(ent_reg.chains) * ADDR_W'(chain_reg);
                state_next  = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (rsp.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg         <= ent_next;
        row_bytes_reg   <= row_bytes_next;
        lvl_reg         <= lvl_next;
        rows_all_reg    <= rows_all_next;
        rows_before_reg <= rows_before_next;
        chain_reg       <= chain_next;
        before_reg      <= before_next;
        offset_reg      <= offset_next;
        total_reg       <= total_next;
    end

endmodule

// ----- sv/mcso_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain surface offset port checker
// Watches the response port of the top level over time.
// ----------------------------------------------------------------------------
`include "mip_chain_surface_offset_top_defines.svh"

module mcso_checker import mcso_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ADDR_W-1:0] byte_offset,
    input logic [DIM_W-1:0]  pitch_texels,
    input logic [DIM_W-1:0]  level_width,
    input logic [DIM_W-1:0]  level_height,
    input logic              bad_request
);

    `MCSO_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(byte_offset) && $stable(bad_request), "stalled response beat changed")
    `MCSO_ASSERT_NOW(a_bad_zero, clk, rst_n, rsp_valid && bad_request, byte_offset == '0, "bad request carries a nonzero offset")
    `MCSO_ASSERT_NOW(a_pitch_align, clk, rst_n, rsp_valid, pitch_texels[PITCH_SHIFT-1:0] == '0, "pitch not aligned")
    `MCSO_ASSERT_NOW(a_level_nonzero, clk, rst_n, rsp_valid, (level_width != '0) && (level_height != '0), "level size of zero")

endmodule

bind mip_chain_surface_offset_top mcso_checker u_mcso_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .byte_offset  (rsp.byte_offset),
    .pitch_texels (rsp.pitch_texels),
    .level_width  (rsp.level_width),
    .level_height (rsp.level_height),
    .bad_request  (rsp.bad_request)
);
